### rtl/mspe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mspe_pkg
// shared types and codes for the stack pool engine
// ----------------------------------------------------------------------------
package mspe_pkg;

    localparam int FuncBits   = 2;
    localparam int IdBits     = 3;
    localparam int CapBits    = 7;
    localparam int WordBits   = 32;
    localparam int StatusBits = 3;

    localparam int InDataBits  = 48;
    localparam int OutDataBits = 40;

    typedef enum logic [FuncBits-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_PUSH    = 2'd1,
        FUNC_POP     = 2'd2,
        FUNC_RELEASE = 2'd3
    } func_t;

    typedef enum logic [StatusBits-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOFREE   = 3'd3,
        ST_NOTALLOC = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_META = 2'd1,
        S_DATA = 2'd2
    } state_t;

endpackage
`default_nettype wire

### rtl/mspe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mspe_ram
// synchronous ram with separate read and write ports, registered read
// ----------------------------------------------------------------------------
module mspe_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 14,
    parameter int ADDR_W = 3
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/multi_stack_pool_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stack_pool_engine_unit
// pool of lifo stacks with per-stack regions in one shared word memory
// ----------------------------------------------------------------------------
// usage:
//   s_* carries request items: s_tuser is the operation (allocate, push,
//   pop, release), s_tdata the stack id, capacity and push word.
//   m_* carries one result item per request: m_tuser is the status,
//   m_tdata the granted id and the popped word.
//   an item is taken when tvalid and tready are both high.
// timing:
//   push, allocate and release go through the lookup state before the
//   result is registered; pop also goes through the word-read state.
//   the next request is taken once the result is loaded into the
//   output register, so no new request is taken while one is in flight.
//   the path is set by the registered reads of the count/limit memory and, for pop, of the word memory.
// reset:
//   every stack is free; neither memory is cleared, no clearing pass.
// stall:
//   a request is still taken while a result waits; its result is held
//   back in the engine until the output register frees up.
// ----------------------------------------------------------------------------
module multi_stack_pool_engine_unit
    import mspe_pkg::*;
#(
    parameter int NUM_STACKS   = 8,
    parameter int STACK_DEPTH  = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // stack_id, capacity, push_word
    input  wire logic [InDataBits-1:0]  s_tdata,
    // func
    input  wire logic [FuncBits-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // granted_id, pop_word
    output logic      [OutDataBits-1:0] m_tdata,
    // status
    output logic      [StatusBits-1:0]  m_tuser
);

    localparam int ID_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int META_W = 2 * CNT_W;
    localparam int WORDS  = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W = $clog2(WORDS);

    state_t                  state_reg, state_next;
    logic [NUM_STACKS-1:0]   free_reg, free_next;
    func_t                   func_reg, func_next;
    logic [IdBits-1:0]       id_reg, id_next;
    logic [CapBits-1:0]      cap_reg, cap_next;
    logic [WordBits-1:0]     word_reg, word_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OutDataBits-1:0]  out_data_reg, out_data_next;
    logic [StatusBits-1:0]   out_user_reg, out_user_next;

    logic                    in_take;
    logic                    slot_free;
    logic [ID_W-1:0]         id_idx;
    logic                    id_valid;
    logic [ID_W-1:0]         grant_idx;
    logic                    any_free;
    logic [CNT_W-1:0]        cap_sat;
    logic [CNT_W-1:0]        cnt_rd, lim_rd;

    logic                    meta_we;
    logic [ID_W-1:0]         meta_waddr;
    logic [META_W-1:0]       meta_wdata, meta_rdata;
    logic                    data_we, data_re;
    logic [ADDR_W-1:0]       data_addr;
    logic [ELEMENT_BITS-1:0] data_rdata;

    assign in_take   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || m_tready;
    assign id_idx    = ID_W'(id_reg);
    assign id_valid  = ({4'd0, id_reg} < 7'(NUM_STACKS));
    assign cnt_rd    = meta_rdata[META_W-1:CNT_W];
    assign lim_rd    = meta_rdata[CNT_W-1:0];
    assign cap_sat   = (int'(cap_reg) > STACK_DEPTH) ? CNT_W'(STACK_DEPTH) : CNT_W'(cap_reg);

    // lowest free stack
    always_comb
    begin
        grant_idx = '0;
        any_free  = 1'b0;
        for (int i = NUM_STACKS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                grant_idx = ID_W'(i);
                any_free  = 1'b1;
            end
        end
    end

    mspe_ram #(
        .DEPTH  (NUM_STACKS),
        .WIDTH  (META_W),
        .ADDR_W (ID_W)
    ) u_meta (
        .clk     (clk),
        .rd_en   (in_take),
        .rd_addr (ID_W'(s_tdata[2:0])),
        .rd_data (meta_rdata),
        .wr_en   (meta_we),
        .wr_addr (meta_waddr),
        .wr_data (meta_wdata)
    );

    mspe_ram #(
        .DEPTH  (WORDS),
        .WIDTH  (ELEMENT_BITS),
        .ADDR_W (ADDR_W)
    ) u_data (
        .clk     (clk),
        .rd_en   (data_re),
        .rd_addr (data_addr),
        .rd_data (data_rdata),
        .wr_en   (data_we),
        .wr_addr (data_addr),
        .wr_data (ELEMENT_BITS'(word_reg))
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        id_reg       <= id_next;
        cap_reg      <= cap_next;
        word_reg     <= word_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        cap_next       = cap_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        meta_we        = 1'b0;
        meta_waddr     = id_idx;
        meta_wdata     = {cnt_rd, lim_rd};
        data_we        = 1'b0;
        data_re        = 1'b0;
        data_addr      = ADDR_W'(32'(id_idx) * STACK_DEPTH + 32'(cnt_rd));

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    func_next  = func_t'(s_tuser);
                    id_next    = s_tdata[2:0];
                    cap_next   = s_tdata[9:3];
                    word_next  = s_tdata[41:10];
                    state_next = S_META;
                end
            end
            S_META:
            begin
                if (func_reg == FUNC_POP && id_valid && !free_reg[id_idx] && cnt_rd != '0)
                begin
                    // pointer update and word read; result goes out next state
                    data_re    = 1'b1;
                    data_addr  = ADDR_W'(32'(id_idx) * STACK_DEPTH + 32'(cnt_rd) - 32'd1);
                    meta_we    = 1'b1;
                    meta_wdata = {cnt_rd - CNT_W'(1), lim_rd};
                    state_next = S_DATA;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_user_next  = ST_OK;
                    state_next     = S_IDLE;
                    priority if (func_reg == FUNC_ALLOC)
                    begin
                        if (any_free)
                        begin
                            free_next[grant_idx] = 1'b0;
                            meta_we       = 1'b1;
                            meta_waddr    = grant_idx;
                            meta_wdata    = {CNT_W'(0), cap_sat};
                            out_data_next = OutDataBits'(IdBits'(grant_idx));
                        end
                        else
                        begin
                            out_user_next = ST_NOFREE;
                        end
                    end
                    else if (func_reg == FUNC_RELEASE)
                    begin
                        if (id_valid)
                        begin
                            free_next[id_idx] = 1'b1;
                        end
                        else
                        begin
                            out_user_next = ST_NOTALLOC;
                        end
                    end
                    else if (!id_valid || free_reg[id_idx])
                    begin
                        out_user_next = ST_NOTALLOC;
                    end
                    else if (func_reg == FUNC_PUSH)
                    begin
                        if (cnt_rd >= lim_rd)
                        begin
                            out_user_next = ST_FULL;
                        end
                        else
                        begin
                            data_we    = 1'b1;
                            meta_we    = 1'b1;
                            meta_wdata = {cnt_rd + CNT_W'(1), lim_rd};
                        end
                    end
                    else
                    begin
                        out_user_next = ST_EMPTY;
                    end
                end
            end
            S_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = ST_OK;
                    out_data_next  = {(OutDataBits - WordBits - IdBits)'(0),
                                      WordBits'(data_rdata), IdBits'(0)};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // an accepted item is always looked up next
    a_accept_meta: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == S_META)
        else $error("accepted item did not enter lookup");

    // failed results carry no id and no word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("failed result carries payload");

    // free bits change only when a lookup finishes
    a_free_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(free_reg) |-> $past(state_reg) == S_META)
        else $error("free bits changed outside lookup");

    // word memory is only written while a lookup has its pointer
    a_data_write: assert property (@(posedge clk) disable iff (!rst_n)
        data_we |-> state_reg == S_META && func_reg == FUNC_PUSH && slot_free)
        else $error("stray word write");

    // the pop word is read in the cycle before the pop result waits
    a_pop_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DATA && $past(state_reg) == S_META |-> $past(data_re))
        else $error("pop result without word read");

endmodule
`default_nettype wire
